[src/grnth_pkg.sv]
// Shared types and constants for the grid ray hitscan core.
// No dependencies; imported by every module of the block.
package grnth_pkg;

  localparam int MAX_TARGETS_DEF = 16;
  localparam int MAP_SIDE_DEF    = 64;
  localparam int FRAC_BITS       = 8;

  localparam int DIR_W  = 16;
  localparam int POS_W  = 14;
  localparam int DIST_W = 16;
  localparam int DIV_W  = 31;

  localparam logic [DIV_W-1:0] DIV_NUM = DIV_W'(1) << 30;

  typedef enum logic [1:0] {
    KIND_CELL  = 2'd0,
    KIND_TGT   = 2'd1,
    KIND_SHOOT = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_HIT_RADIUS = 2'd0,
    CFG_MAP_WIDTH  = 2'd1,
    CFG_MAP_HEIGHT = 2'd2,
    CFG_NONE       = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHOOTER,
    ST_DIVX,
    ST_DIVY,
    ST_SIDEX,
    ST_SIDEY,
    ST_STEP,
    ST_CHECK,
    ST_TREAD,
    ST_MAC,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DIR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             alive;
  } tgt_t;

endpackage

[src/grid_ray_nearest_target_hit_core.sv]
// Grid hitscan core: DDA wall walk, then nearest living target along the ray.
// Depends on grnth_pkg and grnth_div.
// After reset the map is cleared one row a cycle, with no word accepted meanwhile.
// A shoot runs two reciprocals on the shared divider, a DDA walk in which each step
// waits on the registered map read, and per target slot a read, four products on
// the shared multiplier and a compare. A finished result waits in the output
// register while the next word is taken.
module grid_ray_nearest_target_hit_core #(
  parameter int MAX_TARGETS = grnth_pkg::MAX_TARGETS_DEF,
  parameter int MAP_SIDE    = grnth_pkg::MAP_SIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        cell_blocks_i,
  input  logic [3:0]  slot_i,
  input  logic [13:0] pos_x_i,
  input  logic [13:0] pos_y_i,
  input  logic        alive_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [3:0]  target_slot_o,
  output logic [15:0] distance_o
);
  import grnth_pkg::*;

  localparam int AW    = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
  localparam int TW    = $clog2(MAX_TARGETS);
  localparam int GUARD = 4 * MAP_SIDE + 8;
  localparam int GW    = $clog2(GUARD + 1);
  localparam int CW    = $clog2(4 * MAP_SIDE + 72) + 2;
  localparam int SW    = 40 + $clog2(GUARD);
  localparam int MW    = 33;

  state_e state_q, state_d;

  logic [15:0] hr_q;
  logic [6:0]  mw_q, mh_q;

  logic [MAP_SIDE-1:0] mmem [MAP_SIDE];
  logic [MAP_SIDE-1:0] row_q;
  logic [AW-1:0]       clr_q;
  logic [AW-1:0]       mra;
  logic                inr_q;

  tgt_t            tmem [MAX_TARGETS];
  logic [MAX_TARGETS-1:0] tvalid_q;
  tgt_t            trd_q;
  logic            tval_q;
  logic [TW-1:0]   tra;

  logic            acc;
  logic [7:0]      slot8, cx8, cy8;
  logic            slot_ok, cell_ok;

  logic signed [DIR_W-1:0] dx_q, dy_q;
  logic [TW-1:0]   sh_q;
  logic [POS_W-1:0] px_q, py_q;
  logic [DIV_W-1:0] ddx_q, ddy_q;
  logic [SW-1:0]   sdx_q, sdy_q, dist_q;
  logic            infx_q, infy_q, dinf_q;
  logic signed [CW-1:0] cx_q, cy_q, nx, ny, wl, hl;
  logic [GW-1:0]   guard_q;
  logic            take_x, blocked;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [16:0]   ma;
  logic signed [31:0]   mb;
  logic signed [48:0]   prod;
  logic [8:0]           m9;
  logic signed [MW-1:0] along_q, lat_q;
  logic [MW-1:0]        abs_lat, limit;
  logic signed [14:0]   rx, ry;
  logic [1:0]           ph_q;
  logic [TW-1:0]        cnt_q;
  logic [18:0]          d19;
  logic [DIST_W-1:0]    dcand, best_q, wall;
  logic                 found_q, cand_ok;
  logic [TW-1:0]        which_q;

  logic        outv_q, hit_q;
  logic [3:0]  tslot_q;
  logic [15:0] dist_o_q;

  assign acc     = in_valid_i && in_ready_o;
  assign slot8   = 8'(slot_i);
  assign cx8     = 8'(cell_x_i);
  assign cy8     = 8'(cell_y_i);
  assign slot_ok = {1'b0, slot8} < 9'(MAX_TARGETS);
  assign cell_ok = ({1'b0, cx8} < 9'(MAP_SIDE)) && ({1'b0, cy8} < 9'(MAP_SIDE));

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hr_q <= 16'd128;
      mw_q <= 7'd64;
      mh_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_HIT_RADIUS: hr_q <= cfg_wdata_i;
        CFG_MAP_WIDTH:  mw_q <= cfg_wdata_i[6:0];
        CFG_MAP_HEIGHT: mh_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_q == AW'(MAP_SIDE - 1)) state_d = ST_IDLE;
      ST_IDLE:    if (acc && kind_e'(kind_i) == KIND_SHOOT && slot_ok) state_d = ST_SHOOTER;
      ST_SHOOTER: state_d = ST_DIVX;
      ST_DIVX:    if (div_rsp.done) state_d = ST_DIVY;
      ST_DIVY:    if (div_rsp.done) state_d = ST_SIDEX;
      ST_SIDEX:   state_d = ST_SIDEY;
      ST_SIDEY:   state_d = ST_STEP;
      ST_STEP:    state_d = ST_CHECK;
      ST_CHECK:   state_d = (blocked || guard_q == GW'(GUARD)) ? ST_TREAD : ST_STEP;
      ST_TREAD:   state_d = ST_MAC;
      ST_MAC:     if (ph_q == 2'd3) state_d = ST_EVAL;
      ST_EVAL:    state_d = (cnt_q == TW'(MAX_TARGETS - 1)) ? ST_DONE : ST_TREAD;
      ST_DONE:    if (!outv_q || out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o      = 1'b0;
    div_req.start   = 1'b0;
    div_req.divisor = dx_q[15] ? DIR_W'(-dx_q) : DIR_W'(dx_q);
    tra             = cnt_q;
    mra             = ny[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        tra        = slot8[TW-1:0];
      end
      ST_SHOOTER: div_req.start = 1'b1;
      ST_DIVX:    div_req.start = div_rsp.done;
      ST_DIVY:    div_req.divisor = dy_q[15] ? DIR_W'(-dy_q) : DIR_W'(dy_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // map store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == ST_CLEAR) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      mmem[clr_q] <= '0;
    end else if (acc && kind_e'(kind_i) == KIND_CELL && cell_ok) begin
      mmem[cy8[AW-1:0]][cx8[AW-1:0]] <= cell_blocks_i;
    end
    row_q <= mmem[mra];
  end

  // target store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= '0;
    end else if (acc && kind_e'(kind_i) == KIND_TGT && slot_ok) begin
      tvalid_q[slot8[TW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && kind_e'(kind_i) == KIND_TGT && slot_ok) begin
      tmem[slot8[TW-1:0]] <= '{x: pos_x_i, y: pos_y_i, alive: alive_i};
    end
    trd_q  <= tmem[tra];
    tval_q <= tvalid_q[tra];
  end

  grnth_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared multiplier operands
  assign m9 = (state_q == ST_SIDEX)
      ? (dx_q[15] ? 9'(px_q[FRAC_BITS-1:0]) : 9'(1 << FRAC_BITS) - 9'(px_q[FRAC_BITS-1:0]))
      : (dy_q[15] ? 9'(py_q[FRAC_BITS-1:0]) : 9'(1 << FRAC_BITS) - 9'(py_q[FRAC_BITS-1:0]));
  assign rx = $signed({1'b0, trd_q.x}) - $signed({1'b0, px_q});
  assign ry = $signed({1'b0, trd_q.y}) - $signed({1'b0, py_q});

  always_comb begin
    ma = 17'(rx);
    mb = 32'(dx_q);
    if (state_q == ST_SIDEX || state_q == ST_SIDEY) begin
      ma = $signed({8'd0, m9});
      mb = $signed({1'b0, (state_q == ST_SIDEX) ? ddx_q : ddy_q});
    end else begin
      case (ph_q)
        2'd0: begin ma = 17'(rx); mb = 32'(dx_q); end
        2'd1: begin ma = 17'(ry); mb = 32'(dy_q); end
        2'd2: begin ma = 17'(rx); mb = 32'(dy_q); end
        default: begin ma = 17'(ry); mb = 32'(dx_q); end
      endcase
    end
  end
  assign prod = ma * mb;

  // DDA step
  assign take_x = !infx_q && (infy_q || sdx_q < sdy_q);
  assign nx = take_x ? (dx_q[15] ? cx_q - CW'(1) : cx_q + CW'(1)) : cx_q;
  assign ny = take_x ? cy_q : (dy_q[15] ? cy_q - CW'(1) : cy_q + CW'(1));
  assign wl = (CW'(mw_q) > CW'(MAP_SIDE)) ? CW'(MAP_SIDE) : CW'(mw_q);
  assign hl = (CW'(mh_q) > CW'(MAP_SIDE)) ? CW'(MAP_SIDE) : CW'(mh_q);
  assign blocked = !inr_q || row_q[cx_q[AW-1:0]];
  assign wall = (dinf_q || dist_q[SW-1:32] != '0) ? 16'hFFFF : dist_q[31:16];

  // target test
  assign abs_lat = lat_q[MW-1] ? MW'(-lat_q) : MW'(lat_q);
  assign limit   = MW'({hr_q, 14'd0});
  assign d19     = along_q[32:14];
  assign dcand   = (d19[18:16] != 3'd0) ? 16'hFFFF : d19[15:0];
  assign cand_ok = cnt_q != sh_q && trd_q.alive && tval_q && !along_q[MW-1]
                && along_q != '0 && abs_lat <= limit && dcand < best_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        dx_q <= dir_x_i;
        dy_q <= dir_y_i;
        sh_q <= slot8[TW-1:0];
      end
      ST_SHOOTER: begin
        px_q <= tval_q ? trd_q.x : '0;
        py_q <= tval_q ? trd_q.y : '0;
      end
      ST_DIVX: if (div_rsp.done) ddx_q <= div_rsp.quot;
      ST_DIVY: if (div_rsp.done) ddy_q <= div_rsp.quot;
      ST_SIDEX: begin
        sdx_q   <= SW'(prod[38:0]);
        infx_q  <= dx_q == '0;
        cx_q    <= CW'(px_q[POS_W-1:FRAC_BITS]);
        cy_q    <= CW'(py_q[POS_W-1:FRAC_BITS]);
        guard_q <= '0;
        dinf_q  <= 1'b1;
      end
      ST_SIDEY: begin
        sdy_q  <= SW'(prod[38:0]);
        infy_q <= dy_q == '0;
      end
      ST_STEP: begin
        cx_q    <= nx;
        cy_q    <= ny;
        guard_q <= guard_q + GW'(1);
        inr_q   <= !nx[CW-1] && !ny[CW-1] && nx < wl && ny < hl;
        if (take_x) begin
          dist_q <= sdx_q;
          dinf_q <= 1'b0;
          sdx_q  <= sdx_q + SW'({ddx_q, {FRAC_BITS{1'b0}}});
        end else begin
          dist_q <= sdy_q;
          dinf_q <= infy_q;
          if (!infy_q) sdy_q <= sdy_q + SW'({ddy_q, {FRAC_BITS{1'b0}}});
        end
      end
      ST_CHECK: begin
        best_q  <= wall;
        found_q <= 1'b0;
        which_q <= '0;
        cnt_q   <= '0;
        ph_q    <= '0;
      end
      ST_MAC: begin
        ph_q <= ph_q + 2'd1;
        case (ph_q)
          2'd0: along_q <= MW'(prod);
          2'd1: along_q <= along_q + MW'(prod);
          2'd2: lat_q   <= MW'(prod);
          default: lat_q <= lat_q - MW'(prod);
        endcase
      end
      ST_EVAL: begin
        cnt_q <= cnt_q + TW'(1);
        if (cand_ok) begin
          best_q  <= dcand;
          found_q <= 1'b1;
          which_q <= cnt_q;
        end
      end
      default: ;
    endcase
  end

  // output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
    end else if (state_q == ST_DONE && (!outv_q || out_ready_i)) begin
      outv_q <= 1'b1;
    end else if (out_ready_i) begin
      outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!outv_q || out_ready_i)) begin
      hit_q    <= found_q;
      tslot_q  <= found_q ? 4'(which_q) : 4'd0;
      dist_o_q <= best_q;
    end
  end

  assign out_valid_o   = outv_q;
  assign hit_o         = hit_q;
  assign target_slot_o = tslot_q;
  assign distance_o    = dist_o_q;

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(outv_q) |-> $past(state_q) == ST_DONE) else $error("result without shot");
  a_hit_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> distance_o != 16'hFFFF) else $error("hit at saturated range");
  a_miss_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> target_slot_o == 4'd0) else $error("slot on miss");
  a_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> guard_q <= GW'(GUARD)) else $error("walk overrun");

endmodule

[src/grnth_div.sv]
// Restoring divider, one quotient bit per cycle, for the per-cell ray length.
// Depends on grnth_pkg.
module grnth_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  grnth_pkg::div_req_t req_i,
  output grnth_pkg::div_rsp_t rsp_o
);
  import grnth_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [DIR_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DIR_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, req_i.divisor};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= CW'(DIV_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= DIV_NUM;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? DIR_W'(trial - {1'b0, req_i.divisor}) : DIR_W'(trial);
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

[bench/tb_grid_ray_nearest_target_hit_core.sv]
// Testbench for grid_ray_nearest_target_hit_core: random and directed map, combatant and
// shoot words against an in-bench DDA hitscan predictor, with random stalls on both sides.
// Depends on grnth_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_grid_ray_nearest_target_hit_core;
  import grnth_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int SIDE = 64;
  localparam int SLOTS = 16;
  localparam longint unsigned FAR = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    kind_e             kind;
    logic [5:0]        cx;
    logic [5:0]        cy;
    logic              blk;
    logic [3:0]        slot;
    logic [13:0]       px;
    logic [13:0]       py;
    logic              alive;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } word_t;

  typedef struct {
    logic        hit;
    logic [3:0]  tslot;
    logic [15:0] span;
  } shot_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_addr_i = 0;
  logic [15:0] cfg_wdata_i = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic        hit_o;
  logic [3:0]  target_slot_o;
  logic [15:0] distance_o;

  word_t cur_word = '{kind: KIND_NONE, default: '0};
  word_t pending[$];
  shot_t shots_due[$];

  bit          wall_map[SIDE][SIDE];
  logic [13:0] tgt_x[SLOTS] = '{default: '0};
  logic [13:0] tgt_y[SLOTS] = '{default: '0};
  bit          tgt_alive[SLOTS];
  int unsigned radius_q = 128;
  int unsigned width_q = 64;
  int unsigned height_q = 64;

  int  fails = 0;
  int  cycles = 0;
  int  taken_cnt = 0;
  int  seen_cnt = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_cnt = 0;
  bit  hold_req = 0;
  bit  calm = 0;

  grid_ray_nearest_target_hit_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .kind_i(cur_word.kind), .cell_x_i(cur_word.cx), .cell_y_i(cur_word.cy),
    .cell_blocks_i(cur_word.blk), .slot_i(cur_word.slot),
    .pos_x_i(cur_word.px), .pos_y_i(cur_word.py), .alive_i(cur_word.alive),
    .dir_x_i(cur_word.dx), .dir_y_i(cur_word.dy),
    .out_valid_o, .out_ready_i, .hit_o, .target_slot_o, .distance_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit blocked(int x, int y);
    int w;
    int h;
    w = (width_q > SIDE) ? SIDE : width_q;
    h = (height_q > SIDE) ? SIDE : height_q;
    if (x < 0 || y < 0 || x >= w || y >= h) return 1;
    return wall_map[y][x];
  endfunction

  function automatic void axis_start(longint d, logic [13:0] pos,
                                     output longint unsigned step,
                                     output longint unsigned side);
    longint unsigned frac;
    longint unsigned mag;
    frac = pos[7:0];
    if (d == 0) begin
      step = 0;
      side = FAR;
    end else begin
      mag = (d < 0) ? -d : d;
      step = (64'd1 << 30) / mag;
      side = (d < 0) ? frac * step : (256 - frac) * step;
    end
  endfunction

  function automatic logic [15:0] wall_dist(logic [13:0] px, logic [13:0] py,
                                            longint dx, longint dy);
    int cx;
    int cy;
    longint unsigned stx, sty, sdx, sdy, d;
    cx = px >> 8;
    cy = py >> 8;
    axis_start(dx, px, stx, sdx);
    axis_start(dy, py, sty, sdy);
    d = FAR;
    for (int g = 0; g < 4 * SIDE + 8; g++) begin
      if (sdx < sdy) begin
        d = sdx;
        sdx += stx << 8;
        cx += (dx < 0) ? -1 : 1;
      end else begin
        d = sdy;
        if (sdy != FAR) sdy += sty << 8;
        cy += (dy < 0) ? -1 : 1;
      end
      if (blocked(cx, cy)) break;
    end
    if (d == FAR) return 16'hFFFF;
    d = d >> 16;
    return (d > 65535) ? 16'hFFFF : d[15:0];
  endfunction

  function automatic void apply_word(word_t w);
    shot_t r;
    longint dx, dy, rx, ry, along, lat, lim;
    longint unsigned d;
    logic [15:0] best;
    case (w.kind)
      KIND_CELL: wall_map[w.cy][w.cx] = w.blk;
      KIND_TGT: begin
        tgt_x[w.slot] = w.px;
        tgt_y[w.slot] = w.py;
        tgt_alive[w.slot] = w.alive;
      end
      KIND_SHOOT: begin
        dx = w.dx;
        dy = w.dy;
        best = wall_dist(tgt_x[w.slot], tgt_y[w.slot], dx, dy);
        lim = longint'(radius_q) * 16384;
        r.hit = 0;
        r.tslot = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (i == w.slot || !tgt_alive[i]) continue;
          rx = longint'(tgt_x[i]) - longint'(tgt_x[w.slot]);
          ry = longint'(tgt_y[i]) - longint'(tgt_y[w.slot]);
          along = rx * dx + ry * dy;
          lat = rx * dy - ry * dx;
          if (lat < 0) lat = -lat;
          if (along <= 0 || lat > lim) continue;
          d = along >> 14;
          if (d > 65535) d = 65535;
          if (d < best) begin
            best = d[15:0];
            r.hit = 1;
            r.tslot = 4'(i);
          end
        end
        r.span = best;
        shots_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_grid_ray_nearest_target_hit_core: FAIL");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        taken_cnt++;
        apply_word(cur_word);
      end
      if (out_valid_o && out_ready_i) begin
        if (shots_due.size() == 0) begin
          $error("unexpected result: hit %0d slot %0d distance %0d",
                 hit_o, target_slot_o, distance_o);
          fails++;
        end else begin
          shot_t e;
          e = shots_due.pop_front();
          if (hit_o !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, hit_o);
            fails++;
          end
          if (target_slot_o !== e.tslot) begin
            $error("target_slot: expected %0d actual %0d", e.tslot, target_slot_o);
            fails++;
          end
          if (distance_o !== e.span) begin
            $error("distance: expected %0d actual %0d", e.span, distance_o);
            fails++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    bit v;
    if (rst_ni && !(in_valid_i && taken_cnt == seen_cnt)) begin
      v = 0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending.size() != 0) begin
        if (!calm && $urandom_range(0, 4) == 0) begin
          tx_gap = $urandom_range(0, 6);
        end else begin
          cur_word = pending.pop_front();
          v = 1;
        end
      end
      in_valid_i <= v;
    end
    seen_cnt = taken_cnt;
  end

  always @(negedge clk_i) begin
    bit r;
    r = 0;
    if (hold_cnt > 0) begin
      hold_cnt--;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = 3000;
    end else if (rx_gap > 0) begin
      rx_gap--;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      rx_gap = $urandom_range(0, 6);
    end else begin
      r = 1;
    end
    out_ready_i <= r;
  end

  function automatic void add_cell(int x, int y, bit b);
    word_t w;
    w = '{kind: KIND_CELL, default: '0};
    w.cx = 6'(x); w.cy = 6'(y); w.blk = b;
    w.slot = 4'($urandom); w.px = 14'($urandom); w.py = 14'($urandom);
    w.alive = 1'($urandom);
    pending.push_back(w);
  endfunction

  function automatic void add_tgt(int s, int x, int y, bit a);
    word_t w;
    w = '{kind: KIND_TGT, default: '0};
    w.slot = 4'(s); w.px = 14'(x); w.py = 14'(y); w.alive = a;
    w.cx = 6'($urandom); w.cy = 6'($urandom); w.dx = 16'($urandom);
    pending.push_back(w);
  endfunction

  function automatic void add_shot(int s, int dx, int dy);
    word_t w;
    w = '{kind: KIND_SHOOT, default: '0};
    w.slot = 4'(s); w.dx = 16'(dx); w.dy = 16'(dy);
    w.px = 14'($urandom); w.cx = 6'($urandom); w.blk = 1'($urandom);
    pending.push_back(w);
  endfunction

  function automatic int rand_dir();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 1) ? 16384 : -16384;
      2: return $urandom_range(0, 1) ? 11585 : -11585;
      3: return 0;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_HIT_RADIUS: radius_q = val;
      CFG_MAP_WIDTH:  width_q = val[6:0];
      CFG_MAP_HEIGHT: height_q = val[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !in_valid_i && shots_due.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    int cx0, cy0;
    cx0 = $urandom_range(256, 16000);
    cy0 = $urandom_range(256, 16000);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1: add_cell($urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 3) == 0);
        2, 3: begin
          if ($urandom_range(0, 3) == 0)
            add_tgt($urandom_range(0, 15), $urandom_range(0, 16383),
                    $urandom_range(0, 16383), $urandom_range(0, 1));
          else
            add_tgt($urandom_range(0, 15),
                    (cx0 + $urandom_range(0, 1200) - 600) & 16'h3FFF,
                    (cy0 + $urandom_range(0, 1200) - 600) & 16'h3FFF,
                    $urandom_range(0, 4) != 0);
        end
        4: begin
          word_t w;
          w = '{kind: KIND_NONE, default: '0};
          w.slot = 4'($urandom); w.dx = 16'($urandom);
          pending.push_back(w);
        end
        default: add_shot($urandom_range(0, 15), rand_dir(), rand_dir());
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    add_tgt(0, 16383, 16383, 1);
    add_tgt(1, 0, 0, 1);
    add_tgt(2, 2048, 2048, 0);
    add_tgt(3, 2048 + 1024, 2048 + 40, 1);
    add_tgt(4, 2048 - 512, 2048, 1);
    add_tgt(5, 2048 + 700, 2048, 1);
    add_cell(63, 63, 1);
    add_cell(0, 0, 1);
    add_cell(14, 8, 1);
    add_shot(2, 16384, 0);
    add_shot(2, -16384, 0);
    add_shot(2, 0, 0);
    add_shot(2, 0, -16384);
    add_shot(2, -32768, 32767);
    add_shot(0, 16384, 16384);
    add_shot(1, -11585, -11585);
    add_shot(3, -16384, 0);
    add_cell(14, 8, 0);
    add_shot(2, 16384, 1);
    add_tgt(5, 2048 + 700, 2048, 0);
    add_shot(2, 16384, 0);
    begin
      word_t w;
      w = '{kind: KIND_NONE, default: '1};
      pending.push_back(w);
    end
    add_shot(4, 16384, 0);
    drain();

    write_reg(CFG_NONE, 16'hFFFF);
    write_reg(CFG_HIT_RADIUS, 16'd0);
    random_phase(200);
    drain();
    write_reg(CFG_HIT_RADIUS, 16'hFFFF);
    write_reg(CFG_MAP_WIDTH, 16'hFFFF);
    write_reg(CFG_MAP_HEIGHT, 16'd127);
    random_phase(200);
    drain();
    write_reg(CFG_HIT_RADIUS, 16'd512);
    write_reg(CFG_MAP_WIDTH, 16'd16);
    write_reg(CFG_MAP_HEIGHT, 16'd16);
    hold_req = 1;
    random_phase(220);
    drain();
    write_reg(CFG_HIT_RADIUS, 16'd300);
    write_reg(CFG_MAP_WIDTH, 16'd1);
    write_reg(CFG_MAP_HEIGHT, 16'd64);
    random_phase(200);
    drain();
    write_reg(CFG_HIT_RADIUS, 16'd2000);
    write_reg(CFG_MAP_WIDTH, 16'd64);
    write_reg(CFG_MAP_HEIGHT, 16'd1);
    random_phase(200);
    drain();
    write_reg(CFG_HIT_RADIUS, 16'd128);
    write_reg(CFG_MAP_WIDTH, 16'd0);
    write_reg(CFG_MAP_HEIGHT, 16'd40);
    random_phase(150);
    drain();
    write_reg(CFG_MAP_WIDTH, 16'd32);
    write_reg(CFG_MAP_HEIGHT, 16'd0);
    random_phase(100);
    drain();
    write_reg(CFG_HIT_RADIUS, 16'd1024);
    write_reg(CFG_MAP_WIDTH, 16'd32);
    write_reg(CFG_MAP_HEIGHT, 16'd64);
    random_phase(250);
    drain();
    write_reg(CFG_HIT_RADIUS, 16'd800);
    write_reg(CFG_MAP_WIDTH, 16'd64);
    write_reg(CFG_MAP_HEIGHT, 16'd64);
    calm = 1;
    random_phase(250);

    wait (pending.size() == 0 && !in_valid_i && shots_due.size() == 0);
    repeat (800) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_grid_ray_nearest_target_hit_core: PASS");
    end else begin
      $display("tb_grid_ray_nearest_target_hit_core: FAIL");
    end
    $finish;
  end

endmodule
